@@ hdl/tcc_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the
// text console cursor engine. No dependencies.
package tcc_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLS * ROWS;
  localparam int COPY_LEN = COLS * (ROWS - 1);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_GOTO  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // latch incoming word
    logic exec;       // evaluate request, update cursor, write char
    logic sweep;      // one step of the grid copy / blank sweep
    logic cap_cell;   // capture read data of a cell read
    logic load_out;   // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_sweep;
    logic need_read;
    logic sweep_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/tcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone, no package dependency.
module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/tcc_datapath.sv @@
// Datapath: request latch, cursor, grid RAM, sweep pointer, output register.
// Depends on tcc_pkg and tcc_ram.
module tcc_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcc_pkg::dp_cmd_t               cmd,
  output tcc_pkg::dp_stat_t              stat,
  input  logic [1:0]                     in_req_type,
  input  logic [tcc_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tcc_pkg::COL_W-1:0]      in_col,
  input  logic [tcc_pkg::ROW_W-1:0]      in_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcc_pkg::COL_W-1:0]      out_cursor_col,
  output logic [tcc_pkg::ROW_W-1:0]      out_cursor_row,
  output logic [tcc_pkg::CHAR_W-1:0]     out_cell_char,
  output logic                           out_scrolled,
  output logic                           out_status
);

  // latched request
  tcc_pkg::req_t                 req_r;
  logic [tcc_pkg::CHAR_W-1:0]    ch_r;
  logic [tcc_pkg::COL_W-1:0]     col_r;
  logic [tcc_pkg::ROW_W-1:0]     row_r;

  // cursor and per-request results
  logic [tcc_pkg::COL_W-1:0]     cur_col_r, cur_col_nxt;
  logic [tcc_pkg::ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic                          status_r, status_nxt;
  logic                          scrolled_r, scrolled_nxt;
  logic [tcc_pkg::CHAR_W-1:0]    cell_r, cell_nxt;

  // sweep
  logic [tcc_pkg::CNT_W-1:0]     ptr_r;
  logic                          blank_all_r;

  // output register
  logic                          out_valid_r;
  logic [tcc_pkg::COL_W-1:0]     out_col_r;
  logic [tcc_pkg::ROW_W-1:0]     out_row_r;
  logic [tcc_pkg::CHAR_W-1:0]    out_cell_r;
  logic                          out_scr_r;
  logic                          out_sts_r;

  // RAM ports
  logic                          ram_we;
  logic [tcc_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [tcc_pkg::CHAR_W-1:0]    ram_wdata, ram_rdata;

  logic                          in_grid, overflow, put_wr, last_row;
  logic [tcc_pkg::COL_W-1:0]     col_inc;
  logic [tcc_pkg::ROW_W-1:0]     row_inc;
  logic [tcc_pkg::ADDR_W-1:0]    cur_addr, req_addr;
  logic [tcc_pkg::CNT_W-1:0]     ptr_m1, ptr_rd;

  assign in_grid  = (col_r < tcc_pkg::COL_W'(tcc_pkg::COLS)) &&
                    (row_r < tcc_pkg::ROW_W'(tcc_pkg::ROWS));
  assign col_inc  = cur_col_r + tcc_pkg::COL_W'(1);
  assign row_inc  = cur_row_r + tcc_pkg::ROW_W'(1);
  assign last_row = (cur_row_r == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1));

  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    status_nxt   = status_r;
    scrolled_nxt = scrolled_r;
    cell_nxt     = cell_r;
    overflow     = 1'b0;
    put_wr       = 1'b0;
    if (cmd.exec) begin
      status_nxt   = 1'b0;
      scrolled_nxt = 1'b0;
      cell_nxt     = '0;
      unique case (req_r)
        tcc_pkg::REQ_PUT: begin
          priority if (ch_r == tcc_pkg::CH_CR) begin
            cur_col_nxt = '0;
          end else if (ch_r == tcc_pkg::CH_LF) begin
            cur_col_nxt = '0;
            if (last_row) begin
              overflow = 1'b1;
            end else begin
              cur_row_nxt = row_inc;
            end
          end else if (ch_r == tcc_pkg::CH_BS) begin
            if (cur_col_r == '0) begin
              if (cur_row_r != '0) begin
                cur_row_nxt = cur_row_r - tcc_pkg::ROW_W'(1);
                cur_col_nxt = tcc_pkg::COL_W'(tcc_pkg::COLS - 1);
              end
            end else begin
              cur_col_nxt = cur_col_r - tcc_pkg::COL_W'(1);
            end
          end else begin
            put_wr = 1'b1;
            if (col_inc == tcc_pkg::COL_W'(tcc_pkg::COLS)) begin
              cur_col_nxt = '0;
              if (last_row) begin
                overflow = 1'b1;
              end else begin
                cur_row_nxt = row_inc;
              end
            end else begin
              cur_col_nxt = col_inc;
            end
          end
          scrolled_nxt = overflow;
        end
        tcc_pkg::REQ_GOTO: begin
          if (in_grid) begin
            cur_col_nxt = col_r;
            cur_row_nxt = row_r;
          end else begin
            status_nxt = 1'b1;
          end
        end
        tcc_pkg::REQ_CLEAR: begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
        end
        tcc_pkg::REQ_READ: begin
          status_nxt = !in_grid;
        end
      endcase
    end
    if (cmd.cap_cell) begin
      cell_nxt = ram_rdata;
    end
  end

  // grid addressing; sweep writes follow their reads through the registered RAM read
  always_comb begin
    cur_addr  = tcc_pkg::ADDR_W'(cur_row_r) * tcc_pkg::ADDR_W'(tcc_pkg::COLS) +
                tcc_pkg::ADDR_W'(cur_col_r);
    req_addr  = tcc_pkg::ADDR_W'(row_r) * tcc_pkg::ADDR_W'(tcc_pkg::COLS) +
                tcc_pkg::ADDR_W'(col_r);
    ptr_m1    = ptr_r - tcc_pkg::CNT_W'(1);
    ptr_rd    = ptr_r + tcc_pkg::CNT_W'(tcc_pkg::COLS);
    ram_we    = cmd.exec && put_wr;
    ram_waddr = cur_addr;
    ram_wdata = ch_r;
    ram_raddr = req_addr;
    if (cmd.sweep) begin
      if (ptr_r < tcc_pkg::CNT_W'(tcc_pkg::COPY_LEN)) begin
        ram_raddr = ptr_rd[tcc_pkg::ADDR_W-1:0];
      end
      ram_we    = (ptr_r != '0);
      ram_waddr = ptr_m1[tcc_pkg::ADDR_W-1:0];
      ram_wdata = (blank_all_r || (ptr_m1 >= tcc_pkg::CNT_W'(tcc_pkg::COPY_LEN))) ?
                  tcc_pkg::CH_SPACE : ram_rdata;
    end
  end

  tcc_ram #(
    .WIDTH (tcc_pkg::CHAR_W),
    .DEPTH (tcc_pkg::CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      ptr_r       <= '0;
      blank_all_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cmd.exec) begin
        ptr_r       <= '0;
        blank_all_r <= (req_r == tcc_pkg::REQ_CLEAR);
      end else if (cmd.sweep && !stat.sweep_done) begin
        ptr_r <= ptr_r + tcc_pkg::CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    scrolled_r <= scrolled_nxt;
    cell_r     <= cell_nxt;
    if (cmd.load_req) begin
      req_r <= tcc_pkg::req_t'(in_req_type);
      ch_r  <= in_char_code;
      col_r <= in_col;
      row_r <= in_row;
    end
    if (cmd.load_out) begin
      out_col_r  <= cur_col_nxt;
      out_row_r  <= cur_row_nxt;
      out_cell_r <= cell_nxt;
      out_scr_r  <= scrolled_nxt;
      out_sts_r  <= status_nxt;
    end
  end

  assign stat.need_sweep = (req_r == tcc_pkg::REQ_CLEAR) ||
                           ((req_r == tcc_pkg::REQ_PUT) && overflow);
  assign stat.need_read  = (req_r == tcc_pkg::REQ_READ) && in_grid;
  assign stat.sweep_done = (ptr_r == tcc_pkg::CNT_W'(tcc_pkg::CELLS));
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_char  = out_cell_r;
  assign out_scrolled   = out_scr_r;
  assign out_status     = out_sts_r;

endmodule

@@ hdl/tcc_ctrl.sv @@
// Controller state machine: sequences accept, execute, RAM read, sweeps and
// output load. Depends on tcc_pkg.
module tcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcc_pkg::dp_stat_t stat,
  output tcc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_RDWAIT = 6'b001000,
    S_SWEEP  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.need_sweep) begin
          state_nxt = S_SWEEP;
        end else if (stat.need_read) begin
          state_nxt = S_RDWAIT;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd.cap_cell = 1'b1;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          if (stat.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: stream ports, controller and
// datapath. Depends on tcc_pkg, tcc_ctrl, tcc_datapath (and tcc_ram below it).
//
//  channel  | ports           | word contents (low bit first)
//  ---------+-----------------+---------------------------------------------
//  request  | in_t*  (slave)  | tuser: req_type; tdata: char_code, col, row
//  result   | out_t* (master) | tdata: cursor_col, cursor_row, cell_char,
//           |                 |        scrolled, status
//
// Sequencing: put (no scroll) and goto execute directly; read cell adds a RAM
//   read wait unless off the grid; clear and a scrolling put sweep the whole grid,
//   one grid cell per cycle through the single write port of the grid RAM.
// Reset: synchronous, active low; afterwards a blanking pass over all COLS*ROWS
//   cells fills the grid with spaces, in_tready stays low during it.
// Stalls: the result sits in an output register; the next request is taken
//   while it waits, but its own result waits until that register frees up.
module text_console_cursor_engine (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic [23:0] in_tdata,   // [7:0] char_code, [14:8] col, [19:15] row, zero pad
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [6:0] cursor_col, [11:7] cursor_row,
                                  // [19:12] cell_char, [20] scrolled, [21] status
);

  tcc_pkg::dp_cmd_t  cmd;
  tcc_pkg::dp_stat_t stat;

  logic [tcc_pkg::COL_W-1:0]  res_col;
  logic [tcc_pkg::ROW_W-1:0]  res_row;
  logic [tcc_pkg::CHAR_W-1:0] res_cell;
  logic                       res_scrolled;
  logic                       res_status;

  // sequencing: accept, execute, optional read wait or grid sweep, result load
  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // cursor, grid memory and output register
  tcc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_tuser),
    .in_char_code   (in_tdata[7:0]),
    .in_col         (in_tdata[14:8]),
    .in_row         (in_tdata[19:15]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_cursor_col (res_col),
    .out_cursor_row (res_row),
    .out_cell_char  (res_cell),
    .out_scrolled   (res_scrolled),
    .out_status     (res_status)
  );

  assign out_tdata = {2'b00, res_status, res_scrolled, res_cell, res_row, res_col};

endmodule

@@ hdl/tcc_checker.sv @@
// Port-level checks for the text console cursor engine, bound to the top
// level. Depends on tcc_pkg.
module tcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // cursor always reported inside the grid
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] < tcc_pkg::COL_W'(tcc_pkg::COLS)) &&
                   (out_tdata[11:7] < tcc_pkg::ROW_W'(tcc_pkg::ROWS)))
    else $error("cursor outside grid");

  // a scroll leaves the cursor on the last row, status clear
  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |->
      (out_tdata[11:7] == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1)) && !out_tdata[21])
    else $error("scroll with bad cursor row or status");

  // rejected request: no scroll, no cell data
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> !out_tdata[20] && (out_tdata[19:12] == 8'h00))
    else $error("rejected request with scroll or cell data");

  // no request accepted out of reset, at the start of the blanking pass
  a_reset_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request accepted during post-reset blanking");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (.*);
